// File: hdl/ttdar_pkg.sv
// shared constants, action codes and types for the transposition table block
// no dependencies; used by ttdar_ctrl, ttdar_dp and the top level
`default_nettype none

package ttdar_pkg;

    // sizing
    localparam int INDEX_BITS   = 16;
    localparam int MOVE_BITS    = 32;
    localparam int SAMPLE_SLOTS = 1000;

    localparam int SLOT_COUNT = 1 << INDEX_BITS;
    localparam int CNT_W      = $clog2(SAMPLE_SLOTS + 1);

    // field widths of the item ports
    localparam int ACTION_W = 3;
    localparam int KEY_W    = 64;
    localparam int MOVE_W   = 32;
    localparam int DEPTH_W  = 7;
    localparam int SCORE_W  = 16;
    localparam int FLAG_W   = 2;
    localparam int AGE_W    = 3;
    localparam int FULL_W   = 7;
    localparam int CTR_W    = 32;

    // first slot of the fullness sample window, wraps modulo the table size
    localparam logic [INDEX_BITS-1:0] SCAN_BASE = INDEX_BITS'(SLOT_COUNT - SAMPLE_SLOTS);
    localparam logic [INDEX_BITS-1:0] SCAN_LAST = INDEX_BITS'(SAMPLE_SLOTS - 1);

    // divide by ten as multiply by 205 and shift by 11, exact below 1029
    localparam int DIV10_MUL   = 205;
    localparam int DIV10_SHIFT = 11;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_PROBE = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_STORE = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_AGE   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_FULL  = 3'd4;

    // one table slot
    typedef struct packed {
        logic [KEY_W-1:0]          key;
        logic [MOVE_BITS-1:0]      move;
        logic [DEPTH_W-1:0]        depth;
        logic signed [SCORE_W-1:0] score;
        logic [FLAG_W-1:0]         flag;
        logic [AGE_W-1:0]          age;
    } t_slot;

    // controller states
    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_SCAN,
        S_TAIL,
        S_FINISH
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;    // capture item and read its slot
        logic sweep_wr;  // write zero at the walk address
        logic scan_rd;   // read the sample slot at SCAN_BASE plus the walk count
        logic walk_inc;  // advance the walk counter
        logic finish;    // commit the item and load the result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic walk_last_all;
        logic walk_last_scan;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// File: hdl/ttdar_ctrl.sv
// controller state machine for the transposition table block
// depends on ttdar_pkg; drives commands into ttdar_dp
`default_nettype none

module ttdar_ctrl (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    input  wire logic [ttdar_pkg::ACTION_W-1:0] i_action,
    input  wire ttdar_pkg::t_sts                i_sts,
    output ttdar_pkg::t_cmd                     o_cmd,
    output logic                                o_stall
);

    ttdar_pkg::t_state r_state;
    ttdar_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ttdar_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            ttdar_pkg::S_INIT: begin
                o_cmd.sweep_wr = 1'b1;
                o_cmd.walk_inc = 1'b1;
                if (i_sts.walk_last_all) begin
                    n_state = ttdar_pkg::S_IDLE;
                end
            end
            ttdar_pkg::S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_action == ttdar_pkg::ACT_CLEAR) begin
                        n_state = ttdar_pkg::S_CLEAR;
                    end else if (i_action == ttdar_pkg::ACT_FULL) begin
                        n_state = ttdar_pkg::S_SCAN;
                    end else begin
                        n_state = ttdar_pkg::S_FINISH;
                    end
                end
            end
            ttdar_pkg::S_CLEAR: begin
                o_cmd.sweep_wr = 1'b1;
                o_cmd.walk_inc = 1'b1;
                if (i_sts.walk_last_all) begin
                    n_state = ttdar_pkg::S_FINISH;
                end
            end
            ttdar_pkg::S_SCAN: begin
                o_cmd.scan_rd  = 1'b1;
                o_cmd.walk_inc = 1'b1;
                if (i_sts.walk_last_scan) begin
                    n_state = ttdar_pkg::S_TAIL;
                end
            end
            ttdar_pkg::S_TAIL: begin
                // last sample read lands in the count here
                n_state = ttdar_pkg::S_FINISH;
            end
            ttdar_pkg::S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ttdar_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ttdar_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/ttdar_dp.sv
// datapath of the transposition table: slot memory, counters, fill count, result register
// depends on ttdar_pkg; controlled by ttdar_ctrl
`default_nettype none

module ttdar_dp (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire ttdar_pkg::t_cmd                       i_cmd,
    output ttdar_pkg::t_sts                            o_sts,
    input  wire logic [ttdar_pkg::ACTION_W-1:0]        i_action,
    input  wire logic [ttdar_pkg::KEY_W-1:0]           i_key,
    input  wire logic [ttdar_pkg::MOVE_W-1:0]          i_move_word,
    input  wire logic [ttdar_pkg::DEPTH_W-1:0]         i_search_depth,
    input  wire logic signed [ttdar_pkg::SCORE_W-1:0]  i_score_value,
    input  wire logic [ttdar_pkg::FLAG_W-1:0]          i_bound_flag,
    input  wire logic                                  i_stall,
    output logic                                       o_valid,
    output logic                                       o_hit,
    output logic [ttdar_pkg::MOVE_W-1:0]               o_out_move,
    output logic [ttdar_pkg::DEPTH_W-1:0]              o_out_depth,
    output logic signed [ttdar_pkg::SCORE_W-1:0]       o_out_score,
    output logic [ttdar_pkg::FLAG_W-1:0]               o_out_flag,
    output logic [ttdar_pkg::AGE_W-1:0]                o_out_age,
    output logic [ttdar_pkg::FULL_W-1:0]               o_fullness,
    output logic [ttdar_pkg::CTR_W-1:0]                o_hit_total,
    output logic [ttdar_pkg::CTR_W-1:0]                o_miss_total,
    output logic [ttdar_pkg::CTR_W-1:0]                o_write_total
);

    localparam int IW = ttdar_pkg::INDEX_BITS;
    localparam int PW = ttdar_pkg::CNT_W + 8;

    // slot memory
    ttdar_pkg::t_slot mem [ttdar_pkg::SLOT_COUNT];
    ttdar_pkg::t_slot r_rd_data;

    // captured item
    logic [ttdar_pkg::ACTION_W-1:0]       r_action;
    logic [ttdar_pkg::KEY_W-1:0]          r_key;
    logic [ttdar_pkg::MOVE_BITS-1:0]      r_move;
    logic [ttdar_pkg::DEPTH_W-1:0]        r_depth;
    logic signed [ttdar_pkg::SCORE_W-1:0] r_score;
    logic [ttdar_pkg::FLAG_W-1:0]         r_flag;

    // control state
    logic [IW-1:0]                  r_walk;
    logic                           r_scan_pend;
    logic [ttdar_pkg::CNT_W-1:0]    r_fill_cnt;
    logic [ttdar_pkg::AGE_W-1:0]    r_age;
    logic [ttdar_pkg::CTR_W-1:0]    r_hit_ctr;
    logic [ttdar_pkg::CTR_W-1:0]    r_miss_ctr;
    logic [ttdar_pkg::CTR_W-1:0]    r_write_ctr;
    logic                           r_out_valid;

    logic                           w_rd_en;
    logic [IW-1:0]                  w_rd_addr;
    logic                           w_wr_en;
    logic [IW-1:0]                  w_wr_addr;
    ttdar_pkg::t_slot               w_wr_data;
    ttdar_pkg::t_slot               w_new_slot;
    logic                           w_replace;
    logic                           w_hit;
    logic [PW-1:0]                  w_prod;

    function automatic logic [ttdar_pkg::CTR_W-1:0] sat_inc(
        input logic [ttdar_pkg::CTR_W-1:0] v
    );
        return (&v) ? v : v + 1'b1;
    endfunction

    // memory port selection
    always_comb begin
        w_rd_en   = i_cmd.accept || i_cmd.scan_rd;
        w_rd_addr = i_cmd.scan_rd ? ttdar_pkg::SCAN_BASE + r_walk : i_key[IW-1:0];

        w_new_slot.key   = r_key;
        w_new_slot.move  = r_move;
        w_new_slot.depth = r_depth;
        w_new_slot.score = r_score;
        w_new_slot.flag  = r_flag;
        w_new_slot.age   = r_age;

        // depth preferred, stale entries always give way
        w_replace = (r_depth >= r_rd_data.depth) || (r_rd_data.age != r_age);
        w_hit     = (r_rd_data.key == r_key);

        w_wr_en   = i_cmd.sweep_wr ||
                    (i_cmd.finish && (r_action == ttdar_pkg::ACT_STORE) && w_replace);
        w_wr_addr = i_cmd.sweep_wr ? r_walk : r_key[IW-1:0];
        w_wr_data = i_cmd.sweep_wr ? '0 : w_new_slot;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= mem[w_rd_addr];
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_action <= i_action;
            r_key    <= i_key;
            r_move   <= i_move_word[ttdar_pkg::MOVE_BITS-1:0];
            r_depth  <= i_search_depth;
            r_score  <= i_score_value;
            r_flag   <= i_bound_flag;
        end
    end

    // walk counter and fullness count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk      <= '0;
            r_scan_pend <= 1'b0;
        end else begin
            r_scan_pend <= i_cmd.scan_rd;
            if (i_cmd.accept) begin
                r_walk <= '0;
            end else if (i_cmd.walk_inc) begin
                r_walk <= r_walk + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_fill_cnt <= '0;
        end else if (r_scan_pend && (r_rd_data.key != '0)) begin
            r_fill_cnt <= r_fill_cnt + 1'b1;
        end
    end

    assign w_prod = PW'(r_fill_cnt) * PW'(ttdar_pkg::DIV10_MUL);

    // age and counters commit at finish
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age       <= '0;
            r_hit_ctr   <= '0;
            r_miss_ctr  <= '0;
            r_write_ctr <= '0;
        end else if (i_cmd.finish) begin
            unique case (r_action)
                ttdar_pkg::ACT_PROBE: begin
                    if (w_hit) begin
                        r_hit_ctr <= sat_inc(r_hit_ctr);
                    end else begin
                        r_miss_ctr <= sat_inc(r_miss_ctr);
                    end
                end
                ttdar_pkg::ACT_STORE: r_write_ctr <= sat_inc(r_write_ctr);
                ttdar_pkg::ACT_AGE:   r_age <= r_age + 1'b1;
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_hit       <= 1'b0;
            o_out_move  <= '0;
            o_out_depth <= '0;
            o_out_score <= '0;
            o_out_flag  <= '0;
            o_out_age   <= '0;
            o_fullness  <= '0;
            if (r_action == ttdar_pkg::ACT_PROBE) begin
                o_hit       <= w_hit;
                o_out_move  <= ttdar_pkg::MOVE_W'(r_rd_data.move);
                o_out_depth <= r_rd_data.depth;
                o_out_score <= r_rd_data.score;
                o_out_flag  <= r_rd_data.flag;
                o_out_age   <= r_rd_data.age;
            end
            if (r_action == ttdar_pkg::ACT_FULL) begin
                o_fullness <= ttdar_pkg::FULL_W'(w_prod >> ttdar_pkg::DIV10_SHIFT);
            end
            o_hit_total   <= (r_action == ttdar_pkg::ACT_PROBE && w_hit) ?
                             sat_inc(r_hit_ctr) : r_hit_ctr;
            o_miss_total  <= (r_action == ttdar_pkg::ACT_PROBE && !w_hit) ?
                             sat_inc(r_miss_ctr) : r_miss_ctr;
            o_write_total <= (r_action == ttdar_pkg::ACT_STORE) ?
                             sat_inc(r_write_ctr) : r_write_ctr;
        end
    end

    assign o_valid = r_out_valid;

    // status to the controller
    assign o_sts.walk_last_all  = &r_walk;
    assign o_sts.walk_last_scan = (r_walk == ttdar_pkg::SCAN_LAST);
    assign o_sts.out_free       = !r_out_valid || !i_stall;

    // a result is loaded only into a free output register
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (!r_out_valid || !i_stall))
        else $error("result loaded over a pending item");

    // sweep writes never overlap an item commit
    a_sweep_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.sweep_wr && (i_cmd.finish || i_cmd.accept || i_cmd.scan_rd)))
        else $error("sweep overlaps other memory traffic");

    // the fill count never runs past the sample window
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan_pend |-> (r_fill_cnt < ttdar_pkg::CNT_W'(ttdar_pkg::SAMPLE_SLOTS)))
        else $error("fill count beyond sample window");

    // output valid rises only right after a commit
    a_valid_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.finish))
        else $error("output valid without commit");

endmodule

`default_nettype wire

// File: hdl/transposition_table_depth_age_replace.sv
// direct-mapped search result cache with depth and age based replacement
// probe, store, advance age and unused actions read their slot, then commit once the output register is free
// clear zeroes all SLOT_COUNT slots, one slot written per cycle through the single write port
// fullness reads the SAMPLE_SLOTS sample slots, one sample read per cycle, then counts and divides
// one item at a time; a result waits in the output register while the next item is taken
// after reset the slot memory is zeroed by a sweep of every slot, input stalled meanwhile
`default_nettype none

module transposition_table_depth_age_replace (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic [ttdar_pkg::ACTION_W-1:0]        i_action,
    input  wire logic [ttdar_pkg::KEY_W-1:0]           i_key,
    input  wire logic [ttdar_pkg::MOVE_W-1:0]          i_move_word,
    input  wire logic [ttdar_pkg::DEPTH_W-1:0]         i_search_depth,
    input  wire logic signed [ttdar_pkg::SCORE_W-1:0]  i_score_value,
    input  wire logic [ttdar_pkg::FLAG_W-1:0]          i_bound_flag,
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic                                       o_hit,
    output logic [ttdar_pkg::MOVE_W-1:0]               o_out_move,
    output logic [ttdar_pkg::DEPTH_W-1:0]              o_out_depth,
    output logic signed [ttdar_pkg::SCORE_W-1:0]       o_out_score,
    output logic [ttdar_pkg::FLAG_W-1:0]               o_out_flag,
    output logic [ttdar_pkg::AGE_W-1:0]                o_out_age,
    output logic [ttdar_pkg::FULL_W-1:0]               o_fullness,
    output logic [ttdar_pkg::CTR_W-1:0]                o_hit_total,
    output logic [ttdar_pkg::CTR_W-1:0]                o_miss_total,
    output logic [ttdar_pkg::CTR_W-1:0]                o_write_total
);

    ttdar_pkg::t_cmd w_cmd;
    ttdar_pkg::t_sts w_sts;

    // sequencing
    ttdar_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .i_sts    (w_sts),
        .o_cmd    (w_cmd),
        .o_stall  (o_stall)
    );

    // table, counters and result
    ttdar_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_action       (i_action),
        .i_key          (i_key),
        .i_move_word    (i_move_word),
        .i_search_depth (i_search_depth),
        .i_score_value  (i_score_value),
        .i_bound_flag   (i_bound_flag),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_hit          (o_hit),
        .o_out_move     (o_out_move),
        .o_out_depth    (o_out_depth),
        .o_out_score    (o_out_score),
        .o_out_flag     (o_out_flag),
        .o_out_age      (o_out_age),
        .o_fullness     (o_fullness),
        .o_hit_total    (o_hit_total),
        .o_miss_total   (o_miss_total),
        .o_write_total  (o_write_total)
    );

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench for transposition_table_depth_age_replace, driven through valid/stall
// depends on ttdar_pkg and the top level of the block; holds its own behavioral table model

module tb_top;
    import ttdar_pkg::*;

    localparam int LIMIT_CYCLES = 4_000_000;
    localparam int TAIL_CYCLES  = 2000;
    localparam int IDLE_PCT     = 22;
    localparam int HOLD_CYCLES  = 80;
    localparam int HOLD_AT_A    = 60;
    localparam int HOLD_AT_B    = 900;
    localparam int CALM_FIRST   = 300;
    localparam int CALM_LAST    = 500;
    localparam int MAX_PRINT    = 40;
    localparam int POOL_SIZE    = 16;
    localparam int PHASE_ITEMS  = 290;
    localparam int FILL_SLOTS   = SAMPLE_SLOTS / 2;
    localparam int FULL_DIVISOR = 10;

    localparam logic [ACTION_W-1:0] ACT_SPARE_FIRST = ACT_FULL + 1'b1;
    localparam logic [ACTION_W-1:0] ACT_SPARE_LAST  = {ACTION_W{1'b1}};
    localparam logic [CTR_W-1:0]    CTR_TOP         = {CTR_W{1'b1}};
    localparam logic [KEY_W-1:0]    KEY_ALL_ONES    = {KEY_W{1'b1}};

    // one input item as offered to the block
    typedef struct packed {
        logic [ACTION_W-1:0]       action;
        logic [KEY_W-1:0]          key;
        logic [MOVE_W-1:0]         move_word;
        logic [DEPTH_W-1:0]        depth;
        logic signed [SCORE_W-1:0] score;
        logic [FLAG_W-1:0]         flag;
        logic                      wait_drain;
    } tt_item_t;

    // one result item
    typedef struct packed {
        logic                      hit;
        logic [MOVE_W-1:0]         move;
        logic [DEPTH_W-1:0]        depth;
        logic signed [SCORE_W-1:0] score;
        logic [FLAG_W-1:0]         flag;
        logic [AGE_W-1:0]          age;
        logic [FULL_W-1:0]         fullness;
        logic [CTR_W-1:0]          hits;
        logic [CTR_W-1:0]          misses;
        logic [CTR_W-1:0]          writes;
    } tt_result_t;

    // block ports
    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid        = 1'b0;
    logic                      o_stall;
    logic [ACTION_W-1:0]       i_action       = '0;
    logic [KEY_W-1:0]          i_key          = '0;
    logic [MOVE_W-1:0]         i_move_word    = '0;
    logic [DEPTH_W-1:0]        i_search_depth = '0;
    logic signed [SCORE_W-1:0] i_score_value  = '0;
    logic [FLAG_W-1:0]         i_bound_flag   = '0;
    logic                      o_valid;
    logic                      i_stall        = 1'b0;
    logic                      o_hit;
    logic [MOVE_W-1:0]         o_out_move;
    logic [DEPTH_W-1:0]        o_out_depth;
    logic signed [SCORE_W-1:0] o_out_score;
    logic [FLAG_W-1:0]         o_out_flag;
    logic [AGE_W-1:0]          o_out_age;
    logic [FULL_W-1:0]         o_fullness;
    logic [CTR_W-1:0]          o_hit_total;
    logic [CTR_W-1:0]          o_miss_total;
    logic [CTR_W-1:0]          o_write_total;

    // model state
    t_slot            table_mem [SLOT_COUNT];
    logic [AGE_W-1:0] model_age    = '0;
    logic [CTR_W-1:0] model_hits   = '0;
    logic [CTR_W-1:0] model_misses = '0;
    logic [CTR_W-1:0] model_writes = '0;

    // bookkeeping
    tt_item_t         pending_items [$];
    tt_result_t       expected_results [$];
    tt_item_t         offer = '0;
    tt_result_t       seen;
    tt_result_t       want;
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    int               clears_left  = 2;
    int               sent_count   = 0;
    int               rcv_count    = 0;
    int               hold_left    = 0;
    int               err_count    = 0;
    int               cycle_count  = 0;

    transposition_table_depth_age_replace DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_key          (i_key),
        .i_move_word    (i_move_word),
        .i_search_depth (i_search_depth),
        .i_score_value  (i_score_value),
        .i_bound_flag   (i_bound_flag),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_hit          (o_hit),
        .o_out_move     (o_out_move),
        .o_out_depth    (o_out_depth),
        .o_out_score    (o_out_score),
        .o_out_flag     (o_out_flag),
        .o_out_age      (o_out_age),
        .o_fullness     (o_fullness),
        .o_hit_total    (o_hit_total),
        .o_miss_total   (o_miss_total),
        .o_write_total  (o_write_total)
    );

    // clock and reset
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic logic [CTR_W-1:0] sat_inc(input logic [CTR_W-1:0] v);
        return (v == CTR_TOP) ? v : v + 1'b1;
    endfunction

    function automatic void wipe_table();
        for (int i = 0; i < SLOT_COUNT; i++) table_mem[i] = '0;
    endfunction

    // expected result of one item; updates the model state
    function automatic tt_result_t table_predict(input tt_item_t it);
        tt_result_t r;
        t_slot      slot;
        int         idx;
        int         occupied;
        int         s;
        r    = '0;
        idx  = int'(it.key[INDEX_BITS-1:0]);
        slot = table_mem[idx];
        case (it.action)
            ACT_PROBE: begin
                r.hit = (slot.key == it.key);
                if (r.hit) model_hits = sat_inc(model_hits);
                else model_misses = sat_inc(model_misses);
                r.move  = MOVE_W'(slot.move);
                r.depth = slot.depth;
                r.score = slot.score;
                r.flag  = slot.flag;
                r.age   = slot.age;
            end
            ACT_STORE: begin
                // deeper or equal result wins; a stale generation is always replaced
                if (it.depth >= slot.depth || slot.age != model_age) begin
                    slot.key   = it.key;
                    slot.move  = MOVE_BITS'(it.move_word);
                    slot.depth = it.depth;
                    slot.score = it.score;
                    slot.flag  = it.flag;
                    slot.age   = model_age;
                    table_mem[idx] = slot;
                end
                model_writes = sat_inc(model_writes);
            end
            ACT_AGE: model_age = model_age + 1'b1;
            ACT_CLEAR: wipe_table();
            ACT_FULL: begin
                // sample window ends at the last slot of the table
                occupied = 0;
                for (int i = 0; i < SAMPLE_SLOTS; i++) begin
                    s = (SLOT_COUNT - SAMPLE_SLOTS + i) % SLOT_COUNT;
                    if (table_mem[s].key != '0) occupied++;
                end
                r.fullness = FULL_W'(occupied / FULL_DIVISOR);
            end
            default: ;
        endcase
        r.hits   = model_hits;
        r.misses = model_misses;
        r.writes = model_writes;
        return r;
    endfunction

    task automatic queue_item(input logic [ACTION_W-1:0] act, input logic [KEY_W-1:0] key,
                              input logic [MOVE_W-1:0] mv, input logic [DEPTH_W-1:0] depth,
                              input logic signed [SCORE_W-1:0] score,
                              input logic [FLAG_W-1:0] flag, input logic drain);
        tt_item_t it;
        it.action     = act;
        it.key        = key;
        it.move_word  = mv;
        it.depth      = depth;
        it.score      = score;
        it.flag       = flag;
        it.wait_drain = drain;
        pending_items.push_back(it);
    endtask

    function automatic logic [KEY_W-1:0] random_key();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [INDEX_BITS-1:0] window_index();
        return INDEX_BITS'(SCAN_BASE + $urandom_range(0, SAMPLE_SLOTS - 1));
    endfunction

    // random item: half of the keys pooled so probes hit and stores collide
    task automatic queue_random_item();
        logic [ACTION_W-1:0]       act;
        logic [KEY_W-1:0]          key;
        logic [DEPTH_W-1:0]        depth;
        logic signed [SCORE_W-1:0] score;
        int                        pick;
        pick = $urandom_range(0, 99);
        if (pick < 36) act = ACT_PROBE;
        else if (pick < 76) act = ACT_STORE;
        else if (pick < 83) act = ACT_AGE;
        else if (pick < 88) act = ACT_FULL;
        else if (pick < 91) act = ACTION_W'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
        else if (pick < 92 && clears_left > 0) begin
            act = ACT_CLEAR;
            clears_left--;
        end else act = ACT_PROBE;

        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else if (pick < 65) begin
            key = random_key();
        end else if (pick < 85) begin
            key = random_key();
            key[INDEX_BITS-1:0] = window_index();
        end else if (pick < 97) begin
            // same slot as a pooled key, different tag
            key = random_key();
            key[INDEX_BITS-1:0] = key_pool[$urandom_range(0, POOL_SIZE - 1)][INDEX_BITS-1:0];
        end else begin
            key = '0;
        end

        if ($urandom_range(0, 1) == 0) depth = DEPTH_W'($urandom_range(0, 15));
        else depth = DEPTH_W'($urandom_range(0, 127));
        score = SCORE_W'($urandom);
        queue_item(act, key, $urandom, depth, score, FLAG_W'($urandom_range(0, 3)),
                   $urandom_range(0, 99) < 1);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        if (err_count < MAX_PRINT)
            $display("mismatch at result %0d: %s got %0h expected %0h", rcv_count, what,
                     got, exp_val);
        err_count++;
    endtask

    function automatic logic sender_idles();
        if (sent_count >= CALM_FIRST && sent_count < CALM_LAST) return 1'b0;
        return $urandom_range(0, 99) < IDLE_PCT;
    endfunction

    function automatic logic receiver_idles();
        if (rcv_count >= CALM_FIRST && rcv_count < CALM_LAST) return 1'b0;
        return $urandom_range(0, 99) < IDLE_PCT;
    endfunction

    // stimulus
    initial begin
        logic [KEY_W-1:0] key_b;
        logic [KEY_W-1:0] key_c;
        wipe_table();
        for (int i = 0; i < POOL_SIZE; i++) begin
            key_pool[i] = random_key();
            if (i % 2 == 0) key_pool[i][INDEX_BITS-1:0] = window_index();
        end
        key_b = random_key();
        key_b[INDEX_BITS-1:0] = KEY_ALL_ONES[INDEX_BITS-1:0];
        key_c = key_b ^ {1'b1, {(KEY_W-1){1'b0}}};

        // empty table: key zero hits, all ones misses
        queue_item(ACT_PROBE, '0, '0, '0, '0, '0, 1'b0);
        queue_item(ACT_PROBE, KEY_ALL_ONES, '0, '0, '0, '0, 1'b0);
        // extreme store then hit
        queue_item(ACT_STORE, KEY_ALL_ONES, '1, 7'd127, 16'sh8000, 2'd3, 1'b0);
        queue_item(ACT_PROBE, KEY_ALL_ONES, '0, '0, '0, '0, 1'b0);
        // shallower store in the same generation is dropped but counted
        queue_item(ACT_STORE, key_b, 32'h5555_5555, 7'd126, 16'sd1, 2'd1, 1'b0);
        queue_item(ACT_PROBE, KEY_ALL_ONES, '0, '0, '0, '0, 1'b0);
        // equal depth replaces
        queue_item(ACT_STORE, key_b, '0, 7'd127, 16'sh7FFF, 2'd0, 1'b0);
        queue_item(ACT_PROBE, key_b, '0, '0, '0, '0, 1'b0);
        // stale generation replaces even at depth zero
        queue_item(ACT_AGE, '0, '0, '0, '0, '0, 1'b0);
        queue_item(ACT_STORE, key_c, 32'h0F0F_0F0F, 7'd0, 16'shFFFF, 2'd2, 1'b0);
        queue_item(ACT_PROBE, key_c, '0, '0, '0, '0, 1'b0);
        queue_item(ACT_PROBE, key_b, '0, '0, '0, '0, 1'b0);
        // key zero stored and probed
        queue_item(ACT_STORE, '0, 32'hA5A5_A5A5, 7'd9, 16'sd100, 2'd1, 1'b0);
        queue_item(ACT_PROBE, '0, '0, '0, '0, '0, 1'b0);
        queue_item(ACT_FULL, '0, '0, '0, '0, '0, 1'b0);
        // unused actions carry only the counters
        for (int a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++)
            queue_item(ACTION_W'(a), KEY_ALL_ONES, '1, '1, '1, '1, 1'b0);
        queue_item(ACT_CLEAR, '0, '0, '0, '0, '0, 1'b0);
        queue_item(ACT_PROBE, KEY_ALL_ONES, '0, '0, '0, '0, 1'b0);
        queue_item(ACT_FULL, '0, '0, '0, '0, '0, 1'b0);

        for (int i = 0; i < PHASE_ITEMS; i++) queue_random_item();

        // fill half of the sample window so fullness lands mid range
        queue_item(ACT_CLEAR, '0, '0, '0, '0, '0, 1'b0);
        for (int j = 0; j < FILL_SLOTS; j++) begin
            key_b = random_key();
            key_b[INDEX_BITS-1:0] = INDEX_BITS'(SCAN_BASE + j);
            queue_item(ACT_STORE, key_b, $urandom, DEPTH_W'($urandom_range(0, 127)),
                       SCORE_W'($urandom), FLAG_W'($urandom_range(0, 3)), 1'b0);
        end
        queue_item(ACT_FULL, '0, '0, '0, '0, '0, 1'b0);

        // sender pauses here until every result is back
        queue_item(ACT_PROBE, key_b, '0, '0, '0, '0, 1'b1);
        for (int i = 0; i < PHASE_ITEMS; i++) queue_random_item();

        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        while (pending_items.size() != 0 || i_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

    // driver: predict on acceptance, then offer the next pending item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_results.push_back(table_predict(offer));
                sent_count++;
            end
            if (!i_valid || !o_stall) begin
                if (pending_items.size() != 0
                    && (!pending_items[0].wait_drain || expected_results.size() == 0)
                    && !sender_idles()) begin
                    offer = pending_items.pop_front();
                    i_valid        <= 1'b1;
                    i_action       <= offer.action;
                    i_key          <= offer.key;
                    i_move_word    <= offer.move_word;
                    i_search_depth <= offer.depth;
                    i_score_value  <= offer.score;
                    i_bound_flag   <= offer.flag;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                rcv_count++;
                seen.hit      = o_hit;
                seen.move     = o_out_move;
                seen.depth    = o_out_depth;
                seen.score    = o_out_score;
                seen.flag     = o_out_flag;
                seen.age      = o_out_age;
                seen.fullness = o_fullness;
                seen.hits     = o_hit_total;
                seen.misses   = o_miss_total;
                seen.writes   = o_write_total;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", '0, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (seen.hit !== want.hit)
                        report_mismatch("hit", 64'(seen.hit), 64'(want.hit));
                    if (seen.move !== want.move)
                        report_mismatch("move", 64'(seen.move), 64'(want.move));
                    if (seen.depth !== want.depth)
                        report_mismatch("depth", 64'(seen.depth), 64'(want.depth));
                    if (seen.score !== want.score)
                        report_mismatch("score", 64'($unsigned(seen.score)),
                                        64'($unsigned(want.score)));
                    if (seen.flag !== want.flag)
                        report_mismatch("flag", 64'(seen.flag), 64'(want.flag));
                    if (seen.age !== want.age)
                        report_mismatch("age", 64'(seen.age), 64'(want.age));
                    if (seen.fullness !== want.fullness)
                        report_mismatch("fullness", 64'(seen.fullness), 64'(want.fullness));
                    if (seen.hits !== want.hits)
                        report_mismatch("hit_total", 64'(seen.hits), 64'(want.hits));
                    if (seen.misses !== want.misses)
                        report_mismatch("miss_total", 64'(seen.misses), 64'(want.misses));
                    if (seen.writes !== want.writes)
                        report_mismatch("write_total", 64'(seen.writes), 64'(want.writes));
                end
                // long hold-off so the block backs up into its input
                if (rcv_count == HOLD_AT_A || rcv_count == HOLD_AT_B) hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= receiver_idles();
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule
